FILE: rtl/region_scaling_crossover_top_macros.svh
// ----------------------------------------------------------------------------
// Region scaling crossover assertion macros
// Shorthand for clocked implication checks with asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef REGION_SCALING_CROSSOVER_TOP_MACROS_SVH
`define REGION_SCALING_CROSSOVER_TOP_MACROS_SVH

// Same-cycle implication.
`define RSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsc check failed");

// Next-cycle implication.
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsc check failed");

`endif

FILE: rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Widths, codes and constants shared by the region scaling crossover block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

  localparam int unsigned MAX_GENES_DEF = 1024;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned GENE_W   = 8;
  localparam int unsigned FLIGHT_W = 16;
  localparam int unsigned SPLIT_W  = 11;
  localparam int unsigned FAULT_W  = 3;
  localparam int unsigned CFG_W    = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam int unsigned MIN_FLIGHT   = 25;
  localparam int unsigned WIDE_REGION  = 40;
  localparam int unsigned SHORT_REGION = 3;
  localparam int unsigned WIDEN_BY     = 10;
  localparam int unsigned VALUE_LIMIT  = 72;

  localparam logic [CMD_W-1:0] CMD_WR_FATHER = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_MOTHER = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RUN       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RD_SON    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RD_DAUGHT = 3'd4;

  localparam logic [FAULT_W-1:0] FAULT_NONE  = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_SPLIT = 3'd1;
  localparam logic [FAULT_W-1:0] FAULT_START = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_END   = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_VALUE = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/rsc_ram.sv
// ----------------------------------------------------------------------------
// rsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/rsc_div.sv
// ----------------------------------------------------------------------------
// rsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_div #(
  parameter int unsigned NW = 19,
  parameter int unsigned DW = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic      [NW-1:0] quot_o,
  output logic      [DW-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NW-1:0]    quo_q, quo_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dvs_q, dvs_d;
  logic [DW:0]      trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[NW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/region_scaling_crossover_top.sv
// ----------------------------------------------------------------------------
// region_scaling_crossover_top
// Two-parent crossover with linearly resampled swapped regions.
// ----------------------------------------------------------------------------
//
//  channel | signals                               | beat
//  --------+---------------------------------------+-----------------------------
//  in      | in_valid_i / in_stall_o               | cmd, position, gene, splits
//  out     | out_valid_o / out_stall_i             | gene_out, fault_code
//  cfg     | cfg_we_i / cfg_wdata_i                | chromosome_length
//
//  Gene writes and unused commands pass the execute and done states, reads also
//  the read state, before the result beat is registered; the sequencer then is
//  idle again. A run copies both parents into the children, a copy read and a
//  copy write per gene, derives the father and mother regions, then per pass
//  divides lp by lc in setup and per child gene reads, multiplies and divides,
//  each division on the serial divider with NW = clog2(MAX_GENES+1)+8 quotient
//  bits. Reset clears the control state and the sticky fault and loads CFG_RESET
//  into the length register; the gene memories need no clearing. A stalled output
//  beat holds; a new input beat is taken as soon as the sequencer is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module region_scaling_crossover_top #(
  parameter int unsigned MAX_GENES = rsc_pkg::MAX_GENES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic        [rsc_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic        [rsc_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic        [rsc_pkg::POS_W-1:0]    position_i,
  input  wire logic signed [rsc_pkg::GENE_W-1:0]   gene_value_i,
  input  wire logic        [rsc_pkg::FLIGHT_W-1:0] father_flight_len_i,
  input  wire logic        [rsc_pkg::FLIGHT_W-1:0] mother_flight_len_i,
  input  wire logic        [rsc_pkg::SPLIT_W-1:0]  father_split_start_i,
  input  wire logic        [rsc_pkg::SPLIT_W-1:0]  father_split_end_i,
  input  wire logic        [rsc_pkg::SPLIT_W-1:0]  mother_split_start_i,
  input  wire logic        [rsc_pkg::SPLIT_W-1:0]  mother_split_end_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed      [rsc_pkg::GENE_W-1:0]   gene_out_o,
  output logic             [rsc_pkg::FAULT_W-1:0]  fault_code_o
);

  import rsc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_GENES);
  localparam int unsigned LW = $clog2(MAX_GENES + 1);
  localparam int unsigned CW = (LW > 16) ? LW : 16;
  localparam int unsigned PW = LW + 9;
  localparam int unsigned NW = PW - 1;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_EXEC      = 4'd1;
  localparam logic [3:0] S_READ      = 4'd2;
  localparam logic [3:0] S_COPY_RD   = 4'd3;
  localparam logic [3:0] S_COPY_WR   = 4'd4;
  localparam logic [3:0] S_REG_F     = 4'd5;
  localparam logic [3:0] S_REG_M     = 4'd6;
  localparam logic [3:0] S_SETUP     = 4'd7;
  localparam logic [3:0] S_SETUP_W   = 4'd8;
  localparam logic [3:0] S_RD_A      = 4'd9;
  localparam logic [3:0] S_RD_B      = 4'd10;
  localparam logic [3:0] S_MUL0      = 4'd11;
  localparam logic [3:0] S_MUL1      = 4'd12;
  localparam logic [3:0] S_DIV_GO    = 4'd13;
  localparam logic [3:0] S_DIV_W     = 4'd14;
  localparam logic [3:0] S_DONE      = 4'd15;

  // Control state
  logic [3:0]         state_q, state_d;
  logic [CFG_W-1:0]   cfg_q;
  logic [FAULT_W-1:0] sticky_q, sticky_d;
  logic               pass_q, pass_d;
  logic               out_valid_q, out_valid_d;
  logic [GENE_W-1:0]  out_gene_q, out_gene_d;
  logic [FAULT_W-1:0] out_fault_q, out_fault_d;

  // Latched input beat
  logic [CMD_W-1:0]    cmd_q;
  logic [POS_W-1:0]    pos_q;
  logic [GENE_W-1:0]   gene_q;
  logic [FLIGHT_W-1:0] ffl_q, mfl_q;
  logic [SPLIT_W-1:0]  fss_q, fse_q, mss_q, mse_q;

  // Datapath
  logic [LW-1:0]        cp_q, cp_d;
  logic [LW-1:0]        fs_q, fe_q, ms_q, me_q;
  logic [LW-1:0]        fs_d, fe_d, ms_d, me_d;
  logic [LW-1:0]        i_q, i_d, q_q, q_d, r_q, r_d;
  logic [LW-1:0]        qstep_q, qstep_d, rstep_q, rstep_d;
  logic signed [GENE_W-1:0] a_q, a_d, b_q, b_d;
  logic signed [PW-1:0] prod_q, prod_d, num_q, num_d;
  logic                 neg_q, neg_d;
  logic [GENE_W-1:0]    res_q, res_d;

  // Effective length, saturated to [MIN_FLIGHT, MAX_GENES]
  logic [CW-1:0] cfg_ext;
  logic [LW-1:0] len;

  always_comb begin
    cfg_ext = CW'(cfg_q);
    if (cfg_ext < CW'(MIN_FLIGHT)) begin
      len = LW'(MIN_FLIGHT);
    end else if (cfg_ext > CW'(MAX_GENES)) begin
      len = LW'(MAX_GENES);
    end else begin
      len = LW'(cfg_ext);
    end
  end

  // Region derivation, shared by father and mother
  logic [FLIGHT_W-1:0] rg_fl;
  logic [SPLIT_W-1:0]  rg_si, rg_ei;
  logic [CW-1:0]       rg_f, rg_s, rg_e, rg_s1, rg_e1;
  logic [FAULT_W-1:0]  rg_fault;

  always_comb begin
    rg_fl = (state_q == S_REG_M) ? mfl_q : ffl_q;
    rg_si = (state_q == S_REG_M) ? mss_q : fss_q;
    rg_ei = (state_q == S_REG_M) ? mse_q : fse_q;
    rg_f  = CW'(len);
    if (CW'(rg_fl) >= CW'(MIN_FLIGHT) && CW'(rg_fl) < CW'(len)) begin
      rg_f = CW'(rg_fl);
    end
    rg_s     = CW'(rg_si);
    rg_e     = CW'(rg_ei);
    rg_s1    = rg_s;
    rg_e1    = rg_e;
    rg_fault = FAULT_NONE;
    if (rg_s > rg_e || rg_e > rg_f) begin
      rg_fault = FAULT_SPLIT;
    end else begin
      // narrow wide regions to their middle half
      if (rg_e - rg_s > CW'(WIDE_REGION)) begin
        rg_s1 = (rg_s + rg_s + rg_s + rg_e) >> 2;
        rg_e1 = (rg_s + rg_e + rg_e + rg_e) >> 2;
      end
      // widen short regions
      if (rg_e1 < rg_s1 + CW'(SHORT_REGION)) begin
        if (rg_s1 > CW'(WIDEN_BY)) begin
          rg_s1 = rg_s1 - CW'(WIDEN_BY);
        end else begin
          rg_e1 = rg_e1 + CW'(WIDEN_BY);
        end
      end
      if (rg_s1 > rg_e1) begin
        rg_fault = FAULT_START;
      end else if (rg_e1 > rg_f) begin
        rg_fault = FAULT_END;
      end
    end
  end

  // Current resampling pass: daughter from father first, then son from mother
  logic [LW-1:0] ps, pe, cs, ce, lp, lc;
  logic [LW-1:0] par_idx, a_idx;
  logic [LW:0]   r_sum;

  assign ps      = pass_q ? ms_q : fs_q;
  assign pe      = pass_q ? me_q : fe_q;
  assign cs      = pass_q ? fs_q : ms_q;
  assign ce      = pass_q ? fe_q : me_q;
  assign lp      = pe - ps;
  assign lc      = ce - cs;
  assign a_idx   = ps + q_q;
  assign par_idx = ps + q_q + LW'(state_q == S_RD_B || state_q == S_MUL0);
  assign r_sum   = {1'b0, r_q} + {1'b0, rstep_q};

  // Memories
  logic              fa_we, mo_we, so_we, da_we;
  logic [AW-1:0]     par_raddr, chd_raddr, chd_waddr;
  logic [GENE_W-1:0] so_wdata, da_wdata, child_v;
  logic [GENE_W-1:0] fa_rd, mo_rd, so_rd, da_rd, par_rd;

  rsc_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_father (
    .clk_i, .we_i(fa_we), .waddr_i(AW'(pos_q)), .wdata_i(gene_q),
    .raddr_i(par_raddr), .rdata_o(fa_rd)
  );
  rsc_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_mother (
    .clk_i, .we_i(mo_we), .waddr_i(AW'(pos_q)), .wdata_i(gene_q),
    .raddr_i(par_raddr), .rdata_o(mo_rd)
  );
  rsc_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_son (
    .clk_i, .we_i(so_we), .waddr_i(chd_waddr), .wdata_i(so_wdata),
    .raddr_i(chd_raddr), .rdata_o(so_rd)
  );
  rsc_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_daughter (
    .clk_i, .we_i(da_we), .waddr_i(chd_waddr), .wdata_i(da_wdata),
    .raddr_i(chd_raddr), .rdata_o(da_rd)
  );

  assign par_rd = pass_q ? mo_rd : fa_rd;

  // Shared divider
  logic          div_start;
  logic [NW-1:0] div_dividend;
  logic [LW-1:0] div_divisor;
  logic          div_done;
  logic [NW-1:0] div_quot;
  logic [LW-1:0] div_rem;

  rsc_div #(.NW(NW), .DW(LW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_dividend), .divisor_i(div_divisor),
    .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  logic in_accept, out_take, pos_ok, rd_ok;
  logic signed [PW-1:0] num_abs;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign out_take  = out_valid_q && !out_stall_i;
  assign pos_ok    = CW'(pos_q) < CW'(MAX_GENES);
  assign rd_ok     = CW'(pos_q) < CW'(len);
  assign num_abs   = num_q[PW-1] ? -num_q : num_q;
  assign child_v   = neg_q ? (GENE_W'(0) - div_quot[GENE_W-1:0]) : div_quot[GENE_W-1:0];

  // Sequencer
  always_comb begin
    state_d      = state_q;
    sticky_d     = sticky_q;
    pass_d       = pass_q;
    cp_d         = cp_q;
    fs_d         = fs_q;
    fe_d         = fe_q;
    ms_d         = ms_q;
    me_d         = me_q;
    i_d          = i_q;
    q_d          = q_q;
    r_d          = r_q;
    qstep_d      = qstep_q;
    rstep_d      = rstep_q;
    a_d          = a_q;
    b_d          = b_q;
    prod_d       = prod_q;
    num_d        = num_q;
    neg_d        = neg_q;
    res_d        = res_q;
    fa_we        = 1'b0;
    mo_we        = 1'b0;
    so_we        = 1'b0;
    da_we        = 1'b0;
    par_raddr    = AW'(par_idx);
    chd_raddr    = AW'(pos_q);
    chd_waddr    = AW'(cs + i_q);
    so_wdata     = child_v;
    da_wdata     = child_v;
    div_start    = 1'b0;
    div_dividend = NW'(lp);
    div_divisor  = lc;
    out_valid_d  = out_valid_q && !out_take;
    out_gene_d   = out_gene_q;
    out_fault_d  = out_fault_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d = '0;
        case (cmd_q)
          CMD_WR_FATHER: begin
            fa_we   = pos_ok;
            state_d = S_DONE;
          end
          CMD_WR_MOTHER: begin
            mo_we   = pos_ok;
            state_d = S_DONE;
          end
          CMD_RUN: begin
            cp_d    = '0;
            state_d = S_COPY_RD;
          end
          CMD_RD_SON, CMD_RD_DAUGHT: begin
            state_d = S_READ;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_READ: begin
        if (rd_ok) begin
          res_d = (cmd_q == CMD_RD_SON) ? so_rd : da_rd;
        end
        state_d = S_DONE;
      end
      S_COPY_RD: begin
        par_raddr = AW'(cp_q);
        state_d   = (cp_q == len) ? S_REG_F : S_COPY_WR;
      end
      S_COPY_WR: begin
        so_we     = 1'b1;
        da_we     = 1'b1;
        chd_waddr = AW'(cp_q);
        so_wdata  = fa_rd;
        da_wdata  = mo_rd;
        cp_d      = cp_q + LW'(1);
        state_d   = S_COPY_RD;
      end
      S_REG_F: begin
        fs_d = LW'(rg_s1);
        fe_d = LW'(rg_e1);
        if (rg_fault != FAULT_NONE) begin
          if (sticky_q == FAULT_NONE) sticky_d = rg_fault;
          state_d = S_DONE;
        end else begin
          state_d = S_REG_M;
        end
      end
      S_REG_M: begin
        ms_d   = LW'(rg_s1);
        me_d   = LW'(rg_e1);
        pass_d = 1'b0;
        if (rg_fault != FAULT_NONE) begin
          if (sticky_q == FAULT_NONE) sticky_d = rg_fault;
          state_d = S_DONE;
        end else begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        // step of the source index per child gene: lp / lc
        div_start = 1'b1;
        i_d       = '0;
        q_d       = '0;
        r_d       = '0;
        state_d   = S_SETUP_W;
      end
      S_SETUP_W: begin
        if (div_done) begin
          qstep_d = LW'(div_quot);
          rstep_d = div_rem;
          state_d = S_RD_A;
        end
      end
      S_RD_A: begin
        state_d = S_RD_B;
      end
      S_RD_B: begin
        // the read data belongs to the lower source index
        a_d     = (a_idx < len) ? signed'(par_rd) : '0;
        state_d = S_MUL0;
      end
      S_MUL0: begin
        b_d     = (par_idx < len) ? signed'(par_rd) : '0;
        prod_d  = PW'(a_q) * PW'(signed'({1'b0, lc - r_q}));
        state_d = S_MUL1;
      end
      S_MUL1: begin
        num_d   = prod_q + PW'(b_q) * PW'(signed'({1'b0, r_q}));
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start    = 1'b1;
        div_dividend = NW'(num_abs);
        neg_d        = num_q[PW-1];
        state_d      = S_DIV_W;
      end
      S_DIV_W: begin
        if (div_done) begin
          if (div_quot > NW'(VALUE_LIMIT)) begin
            if (sticky_q == FAULT_NONE) sticky_d = FAULT_VALUE;
            state_d = S_DONE;
          end else begin
            da_we = !pass_q;
            so_we = pass_q;
            // advance source position by lp/lc, carrying the remainder
            i_d = i_q + LW'(1);
            if (r_sum >= {1'b0, lc}) begin
              r_d = LW'(r_sum - {1'b0, lc});
              q_d = q_q + qstep_q + LW'(1);
            end else begin
              r_d = LW'(r_sum);
              q_d = q_q + qstep_q;
            end
            if (i_q + LW'(1) == lc) begin
              if (pass_q) begin
                state_d = S_DONE;
              end else begin
                pass_d  = 1'b1;
                state_d = S_SETUP;
              end
            end else begin
              state_d = S_RD_A;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_take) begin
          out_valid_d = 1'b1;
          out_gene_d  = res_q;
          out_fault_d = sticky_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CFG_RESET;
      sticky_q    <= FAULT_NONE;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_gene_q  <= '0;
      out_fault_q <= FAULT_NONE;
    end else begin
      state_q     <= state_d;
      sticky_q    <= sticky_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
      out_gene_q  <= out_gene_d;
      out_fault_q <= out_fault_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers capture the beat on accept; datapath registers advance every cycle
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= cmd_i;
      pos_q  <= position_i;
      gene_q <= gene_value_i;
      ffl_q  <= father_flight_len_i;
      mfl_q  <= mother_flight_len_i;
      fss_q  <= father_split_start_i;
      fse_q  <= father_split_end_i;
      mss_q  <= mother_split_start_i;
      mse_q  <= mother_split_end_i;
    end
    cp_q    <= cp_d;
    fs_q    <= fs_d;
    fe_q    <= fe_d;
    ms_q    <= ms_d;
    me_q    <= me_d;
    i_q     <= i_d;
    q_q     <= q_d;
    r_q     <= r_d;
    qstep_q <= qstep_d;
    rstep_q <= rstep_d;
    a_q     <= a_d;
    b_q     <= b_d;
    prod_q  <= prod_d;
    num_q   <= num_d;
    neg_q   <= neg_d;
    res_q   <= res_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign gene_out_o   = signed'(out_gene_q);
  assign fault_code_o = out_fault_q;

endmodule

`default_nettype wire

FILE: rtl/rsc_checker.sv
// ----------------------------------------------------------------------------
// rsc_checker
// Port-level checks of the region scaling crossover block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "region_scaling_crossover_top_macros.svh"

module rsc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_stall_i,
  input wire logic [rsc_pkg::FAULT_W-1:0]   fault_code_i
);

  import rsc_pkg::*;

  // A stalled result beat stays offered.
  `RSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i)

  // An accepted beat leaves the sequencer busy in the next cycle.
  `RSC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_i, in_stall_i)

  // The first fault since reset is kept.
  `RSC_ASSERT_NEXT(a_fault_sticky, clk_i, rst_ni, fault_code_i != FAULT_NONE, fault_code_i == $past(fault_code_i))

  // Only defined fault codes appear.
  `RSC_ASSERT_IMP(a_fault_range, clk_i, rst_ni, out_valid_i, fault_code_i <= FAULT_VALUE)

endmodule

bind region_scaling_crossover_top rsc_checker u_rsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_i   (in_stall_o),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .fault_code_i (fault_code_o)
);

`default_nettype wire
